FILE: rtl/srw_pkg.sv
`default_nettype none

package srw_pkg;

  localparam int PAY_W   = 32;
  localparam int KIND_W  = 3;
  localparam int WSIZE_W = 4;

  localparam logic [WSIZE_W-1:0] WSIZE_RESET = 4'd8;

  localparam logic [KIND_W-1:0] KIND_DELIVERED = 3'd0;
  localparam logic [KIND_W-1:0] KIND_BUFFERED  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_OUTSIDE   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_ACK       = 3'd3;
  localparam logic [KIND_W-1:0] KIND_NO_ACK    = 3'd4;

  localparam logic CMD_FRAME = 1'b0;
  localparam logic CMD_ACK   = 1'b1;

endpackage

`default_nettype wire

FILE: rtl/selective_repeat_receive_window.sv
// An item passes the input queue and the working registers; its results leave registered.
// A frame passes the idle and classify states; further slots of a run leave from ST_DELIV.
// An ack query scans one slot per cycle while the output is free, up to window_size slots.
// A 2-entry input queue lets new items enter while results wait on out_ready.
// Reset (synchronous, rst_n low): base 1, head slot 0, all slots empty and unacked,
// window_size 8; slot payload storage is not cleared.
`default_nettype none

module selective_repeat_receive_window #(
  parameter int WINDOW   = 8,
  parameter int SEQ_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_command,
  input  wire logic [SEQ_BITS-1:0]           in_frame_seq,
  input  wire logic [srw_pkg::PAY_W-1:0]     in_frame_payload,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [srw_pkg::KIND_W-1:0]         out_result_kind,
  output logic [SEQ_BITS-1:0]                out_result_seq,
  output logic [srw_pkg::PAY_W-1:0]          out_delivered_payload,
  output logic                               out_last,
  input  wire logic                          cfg_we,
  input  wire logic [srw_pkg::WSIZE_W-1:0]   cfg_wdata
);

  import srw_pkg::*;

  logic                q_valid;
  logic                q_pop;
  logic                q_is_ack;
  logic [SEQ_BITS-1:0] q_seq;
  logic [PAY_W-1:0]    q_pay;

  srw_front #(
    .SEQ_BITS(SEQ_BITS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_command      (in_command),
    .in_frame_seq    (in_frame_seq),
    .in_frame_payload(in_frame_payload),
    .q_valid         (q_valid),
    .q_pop           (q_pop),
    .q_is_ack        (q_is_ack),
    .q_seq           (q_seq),
    .q_pay           (q_pay)
  );

  srw_back #(
    .WINDOW  (WINDOW),
    .SEQ_BITS(SEQ_BITS)
  ) u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_wdata            (cfg_wdata),
    .q_valid              (q_valid),
    .q_pop                (q_pop),
    .q_is_ack             (q_is_ack),
    .q_seq                (q_seq),
    .q_pay                (q_pay),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_result_kind      (out_result_kind),
    .out_result_seq       (out_result_seq),
    .out_delivered_payload(out_delivered_payload),
    .out_last             (out_last)
  );

endmodule

`default_nettype wire

FILE: rtl/srw_ram.sv
`default_nettype none

module srw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/srw_front.sv
`default_nettype none

module srw_front #(
  parameter int SEQ_BITS = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic                        in_command,
  input  wire logic [SEQ_BITS-1:0]         in_frame_seq,
  input  wire logic [srw_pkg::PAY_W-1:0]   in_frame_payload,
  output logic                             q_valid,
  input  wire logic                        q_pop,
  output logic                             q_is_ack,
  output logic [SEQ_BITS-1:0]              q_seq,
  output logic [srw_pkg::PAY_W-1:0]        q_pay
);

  import srw_pkg::*;

  logic                cmd_r [2];
  logic [SEQ_BITS-1:0] seq_r [2];
  logic [PAY_W-1:0]    pay_r [2];
  logic                wp_r, wp_nxt;
  logic                rp_r, rp_nxt;
  logic [1:0]          cnt_r, cnt_nxt;
  logic                push;
  logic                pop;

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign pop      = q_pop && q_valid;
  assign q_is_ack = (cmd_r[rp_r] == CMD_ACK);
  assign q_seq    = seq_r[rp_r];
  assign q_pay    = pay_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      cmd_r[wp_r] <= in_command;
      seq_r[wp_r] <= in_frame_seq;
      pay_r[wp_r] <= in_frame_payload;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/srw_back.sv
`default_nettype none

module srw_back #(
  parameter int WINDOW   = 8,
  parameter int SEQ_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [srw_pkg::WSIZE_W-1:0]   cfg_wdata,
  input  wire logic                          q_valid,
  output logic                               q_pop,
  input  wire logic                          q_is_ack,
  input  wire logic [SEQ_BITS-1:0]           q_seq,
  input  wire logic [srw_pkg::PAY_W-1:0]     q_pay,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [srw_pkg::KIND_W-1:0]         out_result_kind,
  output logic [SEQ_BITS-1:0]                out_result_seq,
  output logic [srw_pkg::PAY_W-1:0]          out_delivered_payload,
  output logic                               out_last
);

  import srw_pkg::*;

  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int SUM_W  = ((SLOT_W > CNT_W) ? SLOT_W : CNT_W) + 1;
  localparam int CMP_W  = ((SEQ_BITS > CNT_W) ? SEQ_BITS : CNT_W) + 1;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CLASS = 2'd1;
  localparam logic [1:0] ST_SCAN  = 2'd2;
  localparam logic [1:0] ST_DELIV = 2'd3;

  logic [1:0]          state_r, state_nxt;
  logic                is_ack_r, is_ack_nxt;
  logic [SEQ_BITS-1:0] seq_r, seq_nxt;
  logic [PAY_W-1:0]    pay_r, pay_nxt;
  logic [SEQ_BITS-1:0] base_r, base_nxt;
  logic [SLOT_W-1:0]   head_r, head_nxt;
  logic [WINDOW-1:0]   full_r, full_nxt;
  logic [WINDOW-1:0]   acked_r, acked_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [WSIZE_W-1:0]  wsize_r;

  logic                out_valid_r, out_valid_nxt;
  logic [KIND_W-1:0]   kind_r, kind_nxt;
  logic [SEQ_BITS-1:0] oseq_r, oseq_nxt;
  logic [PAY_W-1:0]    opay_r, opay_nxt;
  logic                last_r, last_nxt;

  logic                ram_we;
  logic [SLOT_W-1:0]   ram_waddr;
  logic                ram_re;
  logic [SLOT_W-1:0]   ram_raddr;
  logic [PAY_W-1:0]    ram_rdata;

  logic [CNT_W-1:0]    win;
  logic [CMP_W-1:0]    off_x;
  logic [CNT_W-1:0]    off_c;
  logic                in_win;
  logic [SLOT_W-1:0]   nh;
  logic                cont;
  logic                out_free;
  logic [SLOT_W-1:0]   off_slot;
  logic [SLOT_W-1:0]   scan_slot;
  logic [SEQ_BITS-1:0] scan_seq;
  logic                scan_end;

  function automatic logic [SLOT_W-1:0] slot_of(input logic [SLOT_W-1:0] h,
                                                input logic [CNT_W-1:0] o);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(h) + SUM_W'(o);
    if (sum >= SUM_W'(WINDOW)) begin
      sum = sum - SUM_W'(WINDOW);
    end
    return sum[SLOT_W-1:0];
  endfunction

  always_comb begin
    if (wsize_r == '0) begin
      win = CNT_W'(1);
    end else if (8'(wsize_r) > 8'(WINDOW)) begin
      win = CNT_W'(WINDOW);
    end else begin
      win = CNT_W'(wsize_r);
    end
  end

  assign off_x     = CMP_W'(SEQ_BITS'(seq_r - base_r));
  assign in_win    = (off_x < CMP_W'(win));
  assign off_c     = off_x[CNT_W-1:0];
  assign off_slot  = slot_of(head_r, off_c);
  assign scan_slot = slot_of(head_r, cnt_r);
  assign scan_seq  = SEQ_BITS'(CMP_W'(base_r) + CMP_W'(cnt_r));
  assign scan_end  = ((CNT_W + 1)'(cnt_r) + (CNT_W + 1)'(1) >= (CNT_W + 1)'(win));
  assign nh        = (head_r == SLOT_W'(WINDOW - 1)) ? '0 : head_r + SLOT_W'(1);
  assign cont      = ((CNT_W + 1)'(cnt_r) + (CNT_W + 1)'(1) < (CNT_W + 1)'(win))
                     && full_r[nh];
  assign out_free  = !out_valid_r || out_ready;

  srw_ram #(
    .WIDTH(PAY_W),
    .DEPTH(WINDOW)
  ) u_slot_ram (
    .clk    (clk),
    .we     (ram_we),
    .waddr  (ram_waddr),
    .wdata  (pay_r),
    .re     (ram_re),
    .raddr  (ram_raddr),
    .rdata_r(ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    is_ack_nxt    = is_ack_r;
    seq_nxt       = seq_r;
    pay_nxt       = pay_r;
    base_nxt      = base_r;
    head_nxt      = head_r;
    full_nxt      = full_r;
    acked_nxt     = acked_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;
    kind_nxt      = kind_r;
    oseq_nxt      = oseq_r;
    opay_nxt      = opay_r;
    last_nxt      = last_r;
    q_pop         = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = off_slot;
    ram_re        = 1'b0;
    ram_raddr     = nh;

    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          is_ack_nxt = q_is_ack;
          seq_nxt    = q_seq;
          pay_nxt    = q_pay;
          cnt_nxt    = '0;
          state_nxt  = q_is_ack ? ST_SCAN : ST_CLASS;
        end
      end
      ST_CLASS: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          oseq_nxt      = seq_r;
          opay_nxt      = '0;
          last_nxt      = 1'b1;
          state_nxt     = ST_IDLE;
          if (!in_win) begin
            kind_nxt = KIND_OUTSIDE;
          end else if (off_c != '0) begin
            kind_nxt           = KIND_BUFFERED;
            ram_we             = 1'b1;
            full_nxt[off_slot] = 1'b1;
          end else begin
            kind_nxt         = KIND_DELIVERED;
            opay_nxt         = pay_r;
            last_nxt         = !cont;
            full_nxt[head_r] = 1'b0;
            acked_nxt[head_r] = 1'b0;
            head_nxt         = nh;
            base_nxt         = base_r + SEQ_BITS'(1);
            ram_re           = 1'b1;
            cnt_nxt          = cnt_r + CNT_W'(1);
            state_nxt        = cont ? ST_DELIV : ST_IDLE;
          end
        end
      end
      ST_DELIV: begin
        if (out_free) begin
          out_valid_nxt     = 1'b1;
          kind_nxt          = KIND_DELIVERED;
          oseq_nxt          = base_r;
          opay_nxt          = ram_rdata;
          last_nxt          = !cont;
          full_nxt[head_r]  = 1'b0;
          acked_nxt[head_r] = 1'b0;
          head_nxt          = nh;
          base_nxt          = base_r + SEQ_BITS'(1);
          ram_re            = 1'b1;
          cnt_nxt           = cnt_r + CNT_W'(1);
          state_nxt         = cont ? ST_DELIV : ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (out_free) begin
          if (full_r[scan_slot] && !acked_r[scan_slot]) begin
            out_valid_nxt        = 1'b1;
            kind_nxt             = KIND_ACK;
            oseq_nxt             = scan_seq;
            opay_nxt             = '0;
            last_nxt             = 1'b1;
            acked_nxt[scan_slot] = 1'b1;
            state_nxt            = ST_IDLE;
          end else if (scan_end) begin
            out_valid_nxt = 1'b1;
            kind_nxt      = KIND_NO_ACK;
            oseq_nxt      = '1;
            opay_nxt      = '0;
            last_nxt      = 1'b1;
            state_nxt     = ST_IDLE;
          end else begin
            cnt_nxt = cnt_r + CNT_W'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      base_r      <= SEQ_BITS'(1);
      head_r      <= '0;
      full_r      <= '0;
      acked_r     <= '0;
      cnt_r       <= '0;
      wsize_r     <= WSIZE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      base_r      <= base_nxt;
      head_r      <= head_nxt;
      full_r      <= full_nxt;
      acked_r     <= acked_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        wsize_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    is_ack_r <= is_ack_nxt;
    seq_r    <= seq_nxt;
    pay_r    <= pay_nxt;
    kind_r   <= kind_nxt;
    oseq_r   <= oseq_nxt;
    opay_r   <= opay_nxt;
    last_r   <= last_nxt;
  end

  assign out_valid             = out_valid_r;
  assign out_result_kind       = kind_r;
  assign out_result_seq        = oseq_r;
  assign out_delivered_payload = opay_r;
  assign out_last              = last_r && !is_ack_r || last_r && is_ack_r;

endmodule

`default_nettype wire

FILE: dv/selective_repeat_receive_window_tb.sv
`default_nettype none

module selective_repeat_receive_window_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import srw_pkg::*;

  localparam int WIN_SLOTS   = 8;
  localparam int SEQ_W       = 16;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE      = 12;
  localparam int LIMIT       = 200000;
  localparam int BURST_ITEMS = 17;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SEQ_W-1:0]  seq;
    logic [PAY_W-1:0]  pay;
    logic              last;
  } result_t;

  class window_scoreboard;
    logic [WSIZE_W-1:0] wsize;
    logic [SEQ_W-1:0]   base;
    logic [2:0]         head;
    logic [PAY_W-1:0]   pay_mem [WIN_SLOTS];
    bit                 full    [WIN_SLOTS];
    bit                 acked   [WIN_SLOTS];
    result_t            expected_q [$];
    result_t            held;
    bit                 have_held;
    int                 errors;
    int                 items;
    int                 results;

    function void clear();
      wsize = WSIZE_RESET;
      base = 16'd1;
      head = 3'd0;
      have_held = 1'b0;
      errors = 0;
      items = 0;
      results = 0;
      for (int i = 0; i < WIN_SLOTS; i++) begin
        pay_mem[i] = '0;
        full[i] = 1'b0;
        acked[i] = 1'b0;
      end
    endfunction

    function void set_window(logic [WSIZE_W-1:0] v);
      wsize = v;
    endfunction

    function int unsigned span();
      if (wsize == 0) return 1;
      if (wsize > WIN_SLOTS) return WIN_SLOTS;
      return wsize;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void emit(logic [KIND_W-1:0] kind, logic [SEQ_W-1:0] seq, logic [PAY_W-1:0] pay);
      if (have_held) expected_q.push_back(held);
      held = '{kind: kind, seq: seq, pay: pay, last: 1'b0};
      have_held = 1'b1;
    endfunction

    function void slide();
      full[head] = 1'b0;
      acked[head] = 1'b0;
      head = head + 3'd1;
      base = base + 16'd1;
    endfunction

    function void note_item(logic cmd, logic [SEQ_W-1:0] seq, logic [PAY_W-1:0] pay);
      int unsigned win;
      int unsigned n;
      logic [SEQ_W-1:0] off;
      logic [2:0] s;
      bit found;
      win = span();
      items++;
      if (cmd == CMD_ACK) begin
        found = 1'b0;
        for (int unsigned k = 0; k < win && !found; k++) begin
          s = head + 3'(k);
          if (full[s] && !acked[s]) begin
            acked[s] = 1'b1;
            emit(KIND_ACK, base + 16'(k), '0);
            found = 1'b1;
          end
        end
        if (!found) emit(KIND_NO_ACK, '1, '0);
      end else begin
        off = seq - base;
        if (off >= win) begin
          emit(KIND_OUTSIDE, seq, '0);
        end else if (off != 0) begin
          s = head + off[2:0];
          pay_mem[s] = pay;
          full[s] = 1'b1;
          emit(KIND_BUFFERED, seq, '0);
        end else begin
          emit(KIND_DELIVERED, base, pay);
          slide();
          n = 1;
          while (n < win && full[head]) begin
            emit(KIND_DELIVERED, base, pay_mem[head]);
            slide();
            n++;
          end
        end
      end
      held.last = 1'b1;
      expected_q.push_back(held);
      have_held = 1'b0;
    endfunction

    function void check_result(result_t got);
      result_t want;
      results++;
      if (expected_q.size() == 0) begin
        $error("unexpected result: result_kind %0d result_seq %0h", got.kind, got.seq);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.kind !== want.kind) begin
        $error("result_kind: expected %0d, actual %0d", want.kind, got.kind);
        errors++;
      end
      if (got.seq !== want.seq) begin
        $error("result_seq: expected %0h, actual %0h", want.seq, got.seq);
        errors++;
      end
      if (got.pay !== want.pay) begin
        $error("delivered_payload: expected %0h, actual %0h", want.pay, got.pay);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0b, actual %0b", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_command = CMD_FRAME;
  logic [SEQ_W-1:0]     in_frame_seq = '0;
  logic [PAY_W-1:0]     in_frame_payload = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [KIND_W-1:0]    out_result_kind;
  logic [SEQ_W-1:0]     out_result_seq;
  logic [PAY_W-1:0]     out_delivered_payload;
  logic                 out_last;
  logic                 cfg_we = 1'b0;
  logic [WSIZE_W-1:0]   cfg_wdata = '0;

  window_scoreboard sb;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_gen = 0;
  int hold_done = 0;
  int hold_left = 0;
  int cycles = 0;

  selective_repeat_receive_window #(
    .WINDOW   (WIN_SLOTS),
    .SEQ_BITS (SEQ_W)
  ) dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_command            (in_command),
    .in_frame_seq          (in_frame_seq),
    .in_frame_payload      (in_frame_payload),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_result_kind       (out_result_kind),
    .out_result_seq        (out_result_seq),
    .out_delivered_payload (out_delivered_payload),
    .out_last              (out_last),
    .cfg_we                (cfg_we),
    .cfg_wdata             (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // hold off the output for a long stretch on request
  always @(posedge clk) begin
    if (hold_gen != hold_done) begin
      hold_done = hold_gen;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_result('{kind: out_result_kind, seq: out_result_seq,
                        pay: out_delivered_payload, last: out_last});
    end
  end

  task automatic send_item(input logic cmd, input logic [SEQ_W-1:0] seq,
                           input logic [PAY_W-1:0] pay);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_frame_seq <= seq;
    in_frame_payload <= pay;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_item(cmd, seq, pay);
  endtask

  task automatic frame(input logic [SEQ_W-1:0] seq, input logic [PAY_W-1:0] pay);
    send_item(CMD_FRAME, seq, pay);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_window(input logic [WSIZE_W-1:0] v);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    sb.set_window(v);
    cfg_we <= 1'b0;
  endtask

  task automatic random_item();
    int unsigned pick;
    int unsigned win;
    logic cmd;
    logic [SEQ_W-1:0] seq;
    logic [PAY_W-1:0] pay;
    win = sb.span();
    pick = $urandom_range(99);
    pay = $urandom;
    cmd = CMD_FRAME;
    if (pick < 15) begin
      cmd = CMD_ACK;
      seq = 16'($urandom);
    end else if (pick < 35) begin
      seq = sb.base;
    end else if (pick < 75) begin
      seq = sb.base + 16'($urandom_range(win - 1));
    end else if (pick < 88) begin
      seq = sb.base + 16'($urandom_range(65535, win));
    end else begin
      seq = 16'($urandom);
    end
    send_item(cmd, seq, pay);
  endtask

  initial begin
    logic [WSIZE_W-1:0] wsel [6];
    sb = new();
    sb.clear();
    wsel = '{4'd3, 4'd1, 4'd8, 4'd0, 4'd5, 4'd2};
    wsel[4] = 4'($urandom_range(15));
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    tx_idle_pct = 38;
    rx_idle_pct = 69;
    send_item(CMD_ACK, 16'h0000, 32'h0000_0000);
    frame(16'h0000, 32'h0000_0000);
    frame(16'hFFFF, 32'hFFFF_FFFF);
    frame(16'd3, 32'hA5A5_A5A5);
    frame(16'd3, 32'h5A5A_5A5A);
    send_item(CMD_ACK, 16'hFFFF, 32'hFFFF_FFFF);
    send_item(CMD_ACK, 16'h0000, 32'h0000_0000);
    frame(16'd8, $urandom);
    frame(16'd2, $urandom);
    frame(16'd1, $urandom);
    for (int s = 5; s <= 11; s++) frame(16'(s), $urandom);
    frame(16'd4, $urandom);
    frame(16'd13, $urandom);
    frame(16'd14, $urandom);
    frame(16'd15, $urandom);
    // shrink: buffered slots stay, the chain stops at the new size
    write_window(4'd2);
    frame(16'd12, $urandom);
    send_item(CMD_ACK, 16'd0, 32'd0);
    write_window(4'd0);
    frame(16'd15, $urandom);
    frame(16'd14, $urandom);
    write_window(4'd15);
    frame(16'd15, $urandom);

    for (int p = 0; p < 6; p++) begin
      write_window(wsel[p]);
      tx_idle_pct = (p < 2) ? 38 : (p < 4) ? 69 : 0;
      rx_idle_pct = (p < 2) ? 69 : (p < 4) ? 38 : 0;
      if (p == 4) hold_gen++;
      for (int i = 0; i < BURST_ITEMS; i++) random_item();
    end

    wait_idle();
    if (sb.pending() != 0) sb.errors++;
    $display("checked %0d items and %0d results over window sizes 0 to 15,", sb.items,
             sb.results);
    $display("three idling profiles and one long output stall with the input backed up");
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
